// File: hdl/adcbtn_pkg.sv
// Package for the ADC ladder button qualifier: widths, codes, register map
// and the structs passed between the qualifier's modules. No dependencies.
package adcbtn_pkg;

  localparam int SAMPLE_BITS  = 12;
  localparam int TIME_BITS    = 32;
  localparam int PRESS_FLOOR  = 124;
  localparam int MS_BITS      = 16;
  localparam int CFG_BITS     = 16;
  localparam int CFG_IDX_BITS = 3;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [TIME_BITS-1:0]   stamp_t;
  typedef logic [MS_BITS-1:0]     ms_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_LEVEL_ENCODER    = 3'd0,
    CFG_LEVEL_PREVIOUS   = 3'd1,
    CFG_LEVEL_PLAY_PAUSE = 3'd2,
    CFG_LEVEL_NEXT       = 3'd3,
    CFG_MATCH_TOLERANCE  = 3'd4,
    CFG_HOLD_AFTER_MS    = 3'd5,
    CFG_LONG_PRESS_MS    = 3'd6,
    CFG_DEBOUNCE_MS      = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    KEY_NONE       = 3'd0,
    KEY_ENCODER    = 3'd1,
    KEY_PREVIOUS   = 3'd2,
    KEY_PLAY_PAUSE = 3'd3,
    KEY_NEXT       = 3'd4
  } key_t;

  typedef enum logic [1:0] {
    STAT_RELEASED = 2'd0,
    STAT_PRESSED  = 2'd1,
    STAT_HELD     = 2'd2,
    STAT_LONG_REL = 2'd3
  } status_t;

  typedef struct packed {
    sample_t level_encoder;
    sample_t level_previous;
    sample_t level_play_pause;
    sample_t level_next;
    sample_t match_tolerance;
    ms_t     hold_after_ms;
    ms_t     long_press_ms;
    ms_t     debounce_ms;
  } cfg_t;

  // One classified sample moving from the input register into the tracker.
  typedef struct packed {
    logic   fire;
    key_t   key;
    stamp_t now_ms;
  } step_t;

  typedef struct packed {
    key_t    pressed_button;
    key_t    released_button;
    status_t press_state;
    stamp_t  held_ms;
  } report_t;

endpackage

// File: hdl/adcbtn_if.sv
// Valid/ready channel interfaces for the button qualifier's input samples
// and status results. Depends on adcbtn_pkg.
interface adcbtn_in_if;
  logic                 valid;
  logic                 ready;
  adcbtn_pkg::sample_t  adc_sample;
  adcbtn_pkg::stamp_t   now_ms;

  modport source (output valid, output adc_sample, output now_ms, input ready);
  modport sink   (input valid, input adc_sample, input now_ms, output ready);
endinterface

interface adcbtn_out_if;
  logic                valid;
  logic                ready;
  logic [2:0]          pressed_button;
  logic [2:0]          released_button;
  logic [1:0]          press_state;
  adcbtn_pkg::stamp_t  held_ms;

  modport source (output valid, output pressed_button, output released_button,
                  output press_state, output held_ms, input ready);
  modport sink   (input valid, input pressed_button, input released_button,
                  input press_state, input held_ms, output ready);
endinterface

// File: hdl/adc_ladder_button_qualifier_core.sv
// Top level of the ADC ladder button qualifier. Depends on adcbtn_pkg,
// adcbtn_if, adcbtn_cfg, adcbtn_classify and adcbtn_tracker.
//
// The block takes one converter sample with its millisecond timestamp per
// item and returns one status item for each, in order. It sustains one item
// per clock cycle while out_chan.ready stays high. An item passes through the
// input register (holding the already classified button) and then the
// tracker, whose state registers form the result register. While a result
// waits on out_chan.ready, one more item is still taken into the input
// register. Configuration writes take effect on the next cycle and are meant
// to be made while no items are in flight.
module adc_ladder_button_qualifier_core (
  input  logic                                clk,
  input  logic                                rst_n,
  adcbtn_in_if.sink                           in_chan,
  adcbtn_out_if.source                        out_chan,
  input  logic                                cfg_we,
  input  logic [adcbtn_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [adcbtn_pkg::CFG_BITS-1:0]     cfg_wdata
);

  adcbtn_pkg::cfg_t    cfg;
  adcbtn_pkg::key_t    in_key;
  adcbtn_pkg::step_t   step;
  adcbtn_pkg::report_t report;

  logic               s1_valid_r, s1_valid_nxt;
  adcbtn_pkg::key_t   s1_key_r;
  adcbtn_pkg::stamp_t s1_now_r;
  logic               out_valid_r, out_valid_nxt;
  logic               advance;
  logic               in_fire;

  adcbtn_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  adcbtn_classify u_classify (
    .adc_sample (in_chan.adc_sample),
    .cfg        (cfg),
    .key        (in_key)
  );

  // The result slot is free, or is emptied at this edge.
  assign advance        = !out_valid_r || out_chan.ready;
  assign in_chan.ready  = !s1_valid_r || advance;
  assign in_fire        = in_chan.valid && in_chan.ready;

  assign step.fire   = s1_valid_r && advance;
  assign step.key    = s1_key_r;
  assign step.now_ms = s1_now_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire)      s1_valid_nxt = 1'b1;
    else if (advance) s1_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (step.fire)           out_valid_nxt = 1'b1;
    else if (out_chan.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_key_r <= in_key;
      s1_now_r <= in_chan.now_ms;
    end
  end

  adcbtn_tracker u_tracker (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .cfg    (cfg),
    .report (report)
  );

  assign out_chan.valid           = out_valid_r;
  assign out_chan.pressed_button  = report.pressed_button;
  assign out_chan.released_button = report.released_button;
  assign out_chan.press_state     = report.press_state;
  assign out_chan.held_ms         = report.held_ms;

  // A button is down exactly when the state is pressed or held.
  a_key_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    (report.pressed_button != adcbtn_pkg::KEY_NONE) ==
    (report.press_state == adcbtn_pkg::STAT_PRESSED ||
     report.press_state == adcbtn_pkg::STAT_HELD))
    else $error("button code and press state disagree");

  // The hold length only moves on an update that reports the held state.
  a_hold_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(report.held_ms) |-> report.press_state == adcbtn_pkg::STAT_HELD)
    else $error("hold length changed outside a held update");

  // Every item that leaves the input register is presented as a result.
  a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    step.fire |=> out_valid_r)
    else $error("tracker step produced no result");

  // A waiting item in the input register is kept while the result stalls.
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> (s1_valid_r && $stable(s1_key_r) &&
                                  $stable(s1_now_r)))
    else $error("stalled input item was lost or altered");

endmodule

// File: hdl/adcbtn_cfg.sv
// Configuration register file of the button qualifier: button levels,
// match tolerance and the three timing thresholds. Depends on adcbtn_pkg.
module adcbtn_cfg (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [adcbtn_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [adcbtn_pkg::CFG_BITS-1:0]        cfg_wdata,
  output adcbtn_pkg::cfg_t                       cfg
);

  adcbtn_pkg::cfg_t cfg_r;
  adcbtn_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (adcbtn_pkg::cfg_idx_t'(cfg_index))
        adcbtn_pkg::CFG_LEVEL_ENCODER:
          cfg_nxt.level_encoder = cfg_wdata[adcbtn_pkg::SAMPLE_BITS-1:0];
        adcbtn_pkg::CFG_LEVEL_PREVIOUS:
          cfg_nxt.level_previous = cfg_wdata[adcbtn_pkg::SAMPLE_BITS-1:0];
        adcbtn_pkg::CFG_LEVEL_PLAY_PAUSE:
          cfg_nxt.level_play_pause = cfg_wdata[adcbtn_pkg::SAMPLE_BITS-1:0];
        adcbtn_pkg::CFG_LEVEL_NEXT:
          cfg_nxt.level_next = cfg_wdata[adcbtn_pkg::SAMPLE_BITS-1:0];
        adcbtn_pkg::CFG_MATCH_TOLERANCE:
          cfg_nxt.match_tolerance = cfg_wdata[adcbtn_pkg::SAMPLE_BITS-1:0];
        adcbtn_pkg::CFG_HOLD_AFTER_MS:
          cfg_nxt.hold_after_ms = cfg_wdata[adcbtn_pkg::MS_BITS-1:0];
        adcbtn_pkg::CFG_LONG_PRESS_MS:
          cfg_nxt.long_press_ms = cfg_wdata[adcbtn_pkg::MS_BITS-1:0];
        adcbtn_pkg::CFG_DEBOUNCE_MS:
          cfg_nxt.debounce_ms = cfg_wdata[adcbtn_pkg::MS_BITS-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.level_encoder    <= '0;
      cfg_r.level_previous   <= '0;
      cfg_r.level_play_pause <= '0;
      cfg_r.level_next       <= '0;
      cfg_r.match_tolerance  <= adcbtn_pkg::sample_t'(124);
      cfg_r.hold_after_ms    <= adcbtn_pkg::ms_t'(200);
      cfg_r.long_press_ms    <= adcbtn_pkg::ms_t'(2000);
      cfg_r.debounce_ms      <= adcbtn_pkg::ms_t'(50);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: hdl/adcbtn_classify.sv
// Maps one converter code to a button: floor test, then the first of the four
// levels within tolerance wins. Purely combinational. Depends on adcbtn_pkg.
module adcbtn_classify (
  input  adcbtn_pkg::sample_t adc_sample,
  input  adcbtn_pkg::cfg_t    cfg,
  output adcbtn_pkg::key_t    key
);

  function automatic logic near_level(input adcbtn_pkg::sample_t s,
                                      input adcbtn_pkg::sample_t lv,
                                      input adcbtn_pkg::sample_t tol);
    adcbtn_pkg::sample_t diff;
    diff = (s >= lv) ? (s - lv) : (lv - s);
    return diff <= tol;
  endfunction

  logic above_floor;
  logic [3:0] hit;

  assign above_floor = adc_sample > adcbtn_pkg::sample_t'(adcbtn_pkg::PRESS_FLOOR);
  assign hit[0] = near_level(adc_sample, cfg.level_encoder, cfg.match_tolerance);
  assign hit[1] = near_level(adc_sample, cfg.level_previous, cfg.match_tolerance);
  assign hit[2] = near_level(adc_sample, cfg.level_play_pause, cfg.match_tolerance);
  assign hit[3] = near_level(adc_sample, cfg.level_next, cfg.match_tolerance);

  always_comb begin
    if (!above_floor)  key = adcbtn_pkg::KEY_NONE;
    else if (hit[0])   key = adcbtn_pkg::KEY_ENCODER;
    else if (hit[1])   key = adcbtn_pkg::KEY_PREVIOUS;
    else if (hit[2])   key = adcbtn_pkg::KEY_PLAY_PAUSE;
    else if (hit[3])   key = adcbtn_pkg::KEY_NEXT;
    else               key = adcbtn_pkg::KEY_NONE;
  end

endmodule

// File: hdl/adcbtn_tracker.sv
// Press/hold/release tracker. Its state registers are also the result
// payload, since every item reports the state it leaves. Depends on adcbtn_pkg.
module adcbtn_tracker (
  input  logic                clk,
  input  logic                rst_n,
  input  adcbtn_pkg::step_t   step,
  input  adcbtn_pkg::cfg_t    cfg,
  output adcbtn_pkg::report_t report
);

  adcbtn_pkg::key_t    cur_key_r, cur_key_nxt;
  adcbtn_pkg::key_t    prev_key_r, prev_key_nxt;
  adcbtn_pkg::status_t status_r, status_nxt;
  adcbtn_pkg::stamp_t  press_stamp_r, press_stamp_nxt;
  adcbtn_pkg::stamp_t  release_stamp_r, release_stamp_nxt;
  adcbtn_pkg::stamp_t  hold_len_r, hold_len_nxt;
  adcbtn_pkg::stamp_t  since_press;
  adcbtn_pkg::stamp_t  since_release;

  // Differences wrap modulo the timestamp width.
  assign since_press   = step.now_ms - press_stamp_r;
  assign since_release = step.now_ms - release_stamp_r;

  always_comb begin
    cur_key_nxt       = cur_key_r;
    prev_key_nxt      = prev_key_r;
    status_nxt        = status_r;
    press_stamp_nxt   = press_stamp_r;
    release_stamp_nxt = release_stamp_r;
    hold_len_nxt      = hold_len_r;
    if (step.fire) begin
      if (step.key != cur_key_r) begin
        if (step.key == adcbtn_pkg::KEY_NONE) begin
          status_nxt = (since_press > adcbtn_pkg::stamp_t'(cfg.long_press_ms)) ?
                       adcbtn_pkg::STAT_LONG_REL : adcbtn_pkg::STAT_RELEASED;
          release_stamp_nxt = step.now_ms;
          prev_key_nxt      = cur_key_r;
          cur_key_nxt       = adcbtn_pkg::KEY_NONE;
        end else if (since_release > adcbtn_pkg::stamp_t'(cfg.debounce_ms)) begin
          // A different button while one is down counts as a new press.
          cur_key_nxt     = step.key;
          status_nxt      = adcbtn_pkg::STAT_PRESSED;
          press_stamp_nxt = step.now_ms;
        end
      end else if (step.key != adcbtn_pkg::KEY_NONE) begin
        if (since_press > adcbtn_pkg::stamp_t'(cfg.hold_after_ms)) begin
          status_nxt   = adcbtn_pkg::STAT_HELD;
          hold_len_nxt = since_press;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_key_r       <= adcbtn_pkg::KEY_NONE;
      prev_key_r      <= adcbtn_pkg::KEY_NONE;
      status_r        <= adcbtn_pkg::STAT_RELEASED;
      press_stamp_r   <= '0;
      release_stamp_r <= '0;
      hold_len_r      <= '0;
    end else begin
      cur_key_r       <= cur_key_nxt;
      prev_key_r      <= prev_key_nxt;
      status_r        <= status_nxt;
      press_stamp_r   <= press_stamp_nxt;
      release_stamp_r <= release_stamp_nxt;
      hold_len_r      <= hold_len_nxt;
    end
  end

  assign report.pressed_button  = cur_key_r;
  assign report.released_button = prev_key_r;
  assign report.press_state     = status_r;
  assign report.held_ms         = hold_len_r;

endmodule

// File: verif/tb_adc_ladder_button_qualifier_core.sv
// Testbench for adc_ladder_button_qualifier_core: drives ladder samples with
// random gaps and stalls and checks each status item against a local tracker.
// Depends on adcbtn_pkg, adcbtn_if and the RTL of the qualifier.
module tb_adc_ladder_button_qualifier_core;
  import adcbtn_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_ITEMS = 250;

  typedef struct {
    sample_t code;
    stamp_t  stamp;
    bit      drain;
  } sample_item_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]     cfg_wdata;

  adcbtn_in_if  in_chan ();
  adcbtn_out_if out_chan ();

  adc_ladder_button_qualifier_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Local copy of the registers and of the tracker state.
  sample_t lvl [4];
  sample_t tol;
  ms_t     hold_cfg, long_cfg, debounce_cfg;
  key_t    cur_key, last_key;
  status_t key_status;
  stamp_t  press_stamp, release_stamp, hold_len;

  sample_item_t sample_q [$];
  report_t      status_q [$];
  sample_item_t tx_item;
  report_t      want;
  stamp_t       t_now;
  int           queued, errors, cycle_count;
  int           tx_gap, rx_stall;
  bit           tx_busy, tx_burst, rx_burst;

  task automatic reset_model();
    foreach (lvl[i]) lvl[i] = '0;
    tol          = sample_t'(124);
    hold_cfg     = ms_t'(200);
    long_cfg     = ms_t'(2000);
    debounce_cfg = ms_t'(50);
    cur_key      = KEY_NONE;
    last_key     = KEY_NONE;
    key_status   = STAT_RELEASED;
    press_stamp  = '0;
    release_stamp = '0;
    hold_len     = '0;
  endtask

  // Classifies one sample, advances the tracker and queues the status it yields.
  task automatic track_button(input sample_t s, input stamp_t now);
    key_t   hit;
    int     diff;
    stamp_t el;
    hit = KEY_NONE;
    if (s > PRESS_FLOOR) begin
      // Scan from the last level down so that the first match in order wins.
      for (int i = 3; i >= 0; i--) begin
        diff = int'(s) - int'(lvl[i]);
        if (diff < 0) diff = -diff;
        if (diff <= int'(tol)) hit = key_t'(i + 1);
      end
    end
    if (hit != cur_key) begin
      if (hit == KEY_NONE) begin
        el = now - press_stamp;
        key_status = (el > long_cfg) ? STAT_LONG_REL : STAT_RELEASED;
        release_stamp = now;
        last_key = cur_key;
        cur_key = KEY_NONE;
      end else begin
        el = now - release_stamp;
        if (el > debounce_cfg) begin
          cur_key = hit;
          key_status = STAT_PRESSED;
          press_stamp = now;
        end
      end
    end else if (hit != KEY_NONE) begin
      el = now - press_stamp;
      if (el > hold_cfg) begin
        key_status = STAT_HELD;
        hold_len = el;
      end
    end
    status_q.push_back('{cur_key, last_key, key_status, hold_len});
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_BITS-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    case (idx)
      CFG_LEVEL_ENCODER:    lvl[0] = v[SAMPLE_BITS-1:0];
      CFG_LEVEL_PREVIOUS:   lvl[1] = v[SAMPLE_BITS-1:0];
      CFG_LEVEL_PLAY_PAUSE: lvl[2] = v[SAMPLE_BITS-1:0];
      CFG_LEVEL_NEXT:       lvl[3] = v[SAMPLE_BITS-1:0];
      CFG_MATCH_TOLERANCE:  tol = v[SAMPLE_BITS-1:0];
      CFG_HOLD_AFTER_MS:    hold_cfg = v;
      CFG_LONG_PRESS_MS:    long_cfg = v;
      CFG_DEBOUNCE_MS:      debounce_cfg = v;
      default: ;
    endcase
  endtask

  // Writes every register; the upper bits of the 12-bit ones carry junk.
  task automatic set_config(input sample_t l_enc, l_prev, l_play, l_next, tol_v,
                            input ms_t hold_v, long_v, deb_v);
    logic [CFG_BITS-SAMPLE_BITS-1:0] junk;
    junk = (CFG_BITS-SAMPLE_BITS)'($urandom);
    write_reg(CFG_LEVEL_ENCODER, {junk, l_enc});
    write_reg(CFG_LEVEL_PREVIOUS, {junk, l_prev});
    write_reg(CFG_LEVEL_PLAY_PAUSE, {junk, l_play});
    write_reg(CFG_LEVEL_NEXT, {junk, l_next});
    write_reg(CFG_MATCH_TOLERANCE, {junk, tol_v});
    write_reg(CFG_HOLD_AFTER_MS, hold_v);
    write_reg(CFG_LONG_PRESS_MS, long_v);
    write_reg(CFG_DEBOUNCE_MS, deb_v);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic ms_t pick_ms();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return ms_t'($urandom_range(0, 20));
      2:       return ms_t'($urandom_range(20, 300));
      3:       return ms_t'($urandom_range(300, 3000));
      4:       return ms_t'($urandom_range(3000, 65535));
      default: return '1;
    endcase
  endfunction

  task automatic random_config();
    sample_t l [4];
    sample_t t;
    foreach (l[i]) l[i] = ($urandom_range(0, 7) == 0) ? sample_t'($urandom)
                                                        : sample_t'($urandom_range(125, 4095));
    case ($urandom_range(0, 3))
      0:       t = sample_t'($urandom_range(0, 40));
      1, 2:    t = sample_t'($urandom_range(0, 300));
      default: t = sample_t'($urandom);
    endcase
    set_config(l[0], l[1], l[2], l[3], t, pick_ms(), pick_ms(), pick_ms());
  endtask

  task automatic push_sample(input sample_t code, input stamp_t stamp);
    sample_item_t it;
    it.code  = code;
    it.stamp = stamp;
    it.drain = ($urandom_range(0, 99) == 0);
    sample_q.push_back(it);
    queued++;
  endtask

  function automatic stamp_t tick(input int span);
    if ($urandom_range(0, 199) == 0) t_now = '1 - $urandom_range(0, 3000);
    else t_now = t_now + $urandom_range(0, span);
    return t_now;
  endfunction

  function automatic sample_t idle_code();
    if ($urandom_range(0, 3) == 0) return sample_t'($urandom);
    return sample_t'($urandom_range(0, PRESS_FLOOR));
  endfunction

  // A code within tolerance of a button level, now and then just outside it.
  function automatic sample_t near_code(input int btn);
    int v, t;
    v = int'(lvl[btn]);
    t = int'(tol);
    if ($urandom_range(0, 9) == 0) v = $urandom_range(0, 1) ? v + t + 1 : v - t - 1;
    else v = v + int'($urandom_range(0, 2 * t)) - t;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return sample_t'(v);
  endfunction

  task automatic press_episode();
    int span, btn;
    case ($urandom_range(0, 4))
      0:       span = 20;
      1:       span = 150;
      2:       span = 600;
      3:       span = 3000;
      default: span = 70000;
    endcase
    repeat ($urandom_range(0, 2)) push_sample(idle_code(), tick(span));
    btn = $urandom_range(0, 3);
    repeat ($urandom_range(1, 10)) begin
      // Occasionally slide to another button without letting go.
      if ($urandom_range(0, 15) == 0) btn = $urandom_range(0, 3);
      push_sample(near_code(btn), tick(span));
    end
    repeat ($urandom_range(1, 3)) push_sample(idle_code(), tick(span));
  endtask

  task automatic fill_phase(input int n);
    int start;
    start = queued;
    while (queued - start < n) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) push_sample(sample_t'($urandom), stamp_t'($urandom));
      end else begin
        press_episode();
      end
    end
  endtask

  // The sender's busy flag already covers an item launched at this very edge.
  task automatic wait_idle();
    do @(posedge clk);
    while (sample_q.size() != 0 || tx_busy || status_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Sender: one item at a time from sample_q, with a random gap after each.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      tx_gap = 0;
    end else begin
      tx_busy = in_chan.valid;
      if (in_chan.valid && in_chan.ready) begin
        track_button(in_chan.adc_sample, in_chan.now_ms);
        tx_busy = 1'b0;
        if ($urandom_range(0, 49) == 0) tx_burst = !tx_burst;
        tx_gap = tx_burst ? 0 : $urandom_range(0, 9);
      end
      if (!tx_busy) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (sample_q.size() != 0 && !(sample_q[0].drain && status_q.size() != 0)) begin
          tx_item = sample_q.pop_front();
          in_chan.adc_sample <= tx_item.code;
          in_chan.now_ms     <= tx_item.stamp;
          tx_busy = 1'b1;
        end
      end
      in_chan.valid <= tx_busy;
    end
  end

  // Receiver: checks each status item and stalls at random after it.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (status_q.size() == 0) begin
          $error("status item arrived with none expected");
          errors++;
        end else begin
          want = status_q.pop_front();
          if (out_chan.pressed_button !== want.pressed_button) begin
            $error("pressed_button: expected %0d, got %0d", want.pressed_button,
                   out_chan.pressed_button);
            errors++;
          end
          if (out_chan.released_button !== want.released_button) begin
            $error("released_button: expected %0d, got %0d", want.released_button,
                   out_chan.released_button);
            errors++;
          end
          if (out_chan.press_state !== want.press_state) begin
            $error("press_state: expected %0d, got %0d", want.press_state,
                   out_chan.press_state);
            errors++;
          end
          if (out_chan.held_ms !== want.held_ms) begin
            $error("held_ms: expected %0d, got %0d", want.held_ms, out_chan.held_ms);
            errors++;
          end
        end
        if ($urandom_range(0, 49) == 0) rx_burst = !rx_burst;
        rx_stall = rx_burst ? 0 : $urandom_range(0, 9);
      end else if (rx_stall > 0) begin
        rx_stall--;
      end
      out_chan.ready <= (rx_stall == 0);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[adc_ladder_button_qualifier_core] ERROR");
    $finish;
  end

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_LEVEL_ENCODER;
    cfg_wdata          = '0;
    in_chan.valid      = 1'b0;
    in_chan.adc_sample = '0;
    in_chan.now_ms     = '0;
    out_chan.ready     = 1'b0;
    reset_model();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // With the reset levels all at zero no sample can select a button.
    push_sample(12'd0, 32'd0);
    push_sample(12'd4095, 32'hFFFF_FFFF);
    push_sample(12'd125, 32'd5);
    wait_idle();

    set_config(12'd500, 12'd1200, 12'd2000, 12'd3000, 12'd124, 16'd200, 16'd2000, 16'd50);
    // The release time is still zero, so the first presses fall in the debounce window.
    push_sample(12'd500, 32'd10);
    push_sample(12'd510, 32'd50);
    push_sample(12'd490, 32'd51);
    push_sample(12'd500, 32'd251);
    push_sample(12'd500, 32'd252);
    push_sample(12'd1200, 32'd300);
    push_sample(12'd124, 32'd2301);
    push_sample(12'd125, 32'd2400);
    push_sample(12'd2124, 32'd3000);
    push_sample(12'd1876, 32'd3050);
    push_sample(12'd0, 32'd3100);
    push_sample(12'd3000, 32'd3130);
    push_sample(12'd2876, 32'd3200);
    push_sample(12'd3125, 32'd3300);
    // Press just before the timestamp wraps and hold across it.
    push_sample(12'd500, 32'hFFFF_FF00);
    push_sample(12'd500, 32'h0000_0100);
    push_sample(12'd100, 32'h0000_0900);
    wait_idle();

    // All levels overlap, so the encoder always wins; every time at its maximum.
    set_config(12'd2048, 12'd2048, 12'd2048, 12'd2048, 12'd4095, 16'hFFFF, 16'hFFFF,
               16'hFFFF);
    push_sample(12'd2048, 32'h0000_0900 + 32'd65535);
    push_sample(12'd4095, 32'h0000_0900 + 32'd65536);
    t_now = 32'h0002_0000;
    fill_phase(PHASE_ITEMS);
    wait_idle();

    set_config(12'd125, 12'd4095, 12'd0, 12'd126, 12'd0, 16'd0, 16'd0, 16'd0);
    fill_phase(PHASE_ITEMS);
    wait_idle();

    repeat (5) begin
      random_config();
      fill_phase(PHASE_ITEMS);
      wait_idle();
    end

    set_config(12'd500, 12'd1200, 12'd2000, 12'd3000, 12'd124, 16'd200, 16'd2000, 16'd50);
    fill_phase(PHASE_ITEMS);
    wait_idle();
    repeat (6) @(posedge clk);

    if (errors == 0 && status_q.size() == 0) begin
      $display("[adc_ladder_button_qualifier_core] OK");
    end else begin
      $display("[adc_ladder_button_qualifier_core] ERROR");
    end
    $finish;
  end

endmodule
